@@ rtl/msp_rx_pkg.sv @@
package msp_rx_pkg;

    localparam logic [7:0] MARK_DOLLAR = 8'h24;
    localparam logic [7:0] MARK_M      = 8'h4D;
    localparam logic [7:0] MARK_GT     = 8'h3E;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_M    = 3'd1,
        PH_GT   = 3'd2,
        PH_SIZE = 3'd3,
        PH_CMD  = 3'd4,
        PH_DATA = 3'd5,
        PH_SUM  = 3'd6
    } phase_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_END     = 1'b1
    } kind_t;

endpackage

@@ rtl/msp_frame_receiver_core.sv @@
// Channel   | valid     | ready     | payload
// ----------+-----------+-----------+--------------------------------------------
// receive   | rx_valid  | rx_ready  | rx_byte
// result    | res_valid | res_ready | result_kind, payload_byte, payload_index,
//           |           |           | command_code, frame_length, checksum_ok
//
// One byte is taken per cycle unless a stalled result holds it, as told below.
// The input register feeds the phase logic, whose result lands in the output register.
// rst_n clears the parser to hunting for the start mark and empties both registers.
// A stalled result holds only bytes that give a result; header bytes still flow.
module msp_frame_receiver_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    input  logic       res_ready,
    output logic       result_kind,
    output logic [7:0] payload_byte,
    output logic [7:0] payload_index,
    output logic [7:0] command_code,
    output logic [7:0] frame_length,
    output logic       checksum_ok
);
    import msp_rx_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    phase_t     phase_reg, phase_next;
    logic [7:0] size_reg, size_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] xor_reg, xor_next;

    logic       out_valid_reg;
    logic       out_kind_reg;
    logic [7:0] out_byte_reg;
    logic [7:0] out_index_reg;
    logic [7:0] out_cmd_reg;
    logic [7:0] out_len_reg;
    logic       out_ok_reg;

    logic       emit;
    logic       out_free;
    logic       advance;
    logic [7:0] count_inc;

    assign out_free  = !out_valid_reg || res_ready;
    assign advance   = in_valid_reg && (!emit || out_free);
    assign rx_ready  = !in_valid_reg || advance;
    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        size_next  = size_reg;
        cmd_next   = cmd_reg;
        count_next = count_reg;
        xor_next   = xor_reg;
        emit       = 1'b0;
        unique case (phase_reg)
            PH_M:
            begin
                phase_next = (in_byte_reg == MARK_M) ? PH_GT : PH_HUNT;
            end
            PH_GT:
            begin
                phase_next = (in_byte_reg == MARK_GT) ? PH_SIZE : PH_HUNT;
            end
            PH_SIZE:
            begin
                size_next  = in_byte_reg;
                xor_next   = in_byte_reg;
                count_next = 8'd0;
                phase_next = PH_CMD;
            end
            PH_CMD:
            begin
                cmd_next   = in_byte_reg;
                xor_next   = xor_reg ^ in_byte_reg;
                phase_next = (size_reg == 8'd0) ? PH_SUM : PH_DATA;
            end
            PH_DATA:
            begin
                xor_next   = xor_reg ^ in_byte_reg;
                count_next = count_inc;
                emit       = 1'b1;
                if (count_inc == size_reg)
                begin
                    phase_next = PH_SUM;
                end
            end
            PH_SUM:
            begin
                emit       = 1'b1;
                phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = (in_byte_reg == MARK_DOLLAR) ? PH_M : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx_ready)
        begin
            in_valid_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            size_reg  <= 8'd0;
            cmd_reg   <= 8'd0;
            count_reg <= 8'd0;
            xor_reg   <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            size_reg  <= size_next;
            cmd_reg   <= cmd_next;
            count_reg <= count_next;
            xor_reg   <= xor_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && emit;
        end
    end

    // load the result for the request that leaves the input register
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_cmd_reg <= cmd_reg;
            out_len_reg <= size_reg;
            if (phase_reg == PH_SUM)
            begin
                out_kind_reg  <= KIND_END;
                out_byte_reg  <= 8'd0;
                out_index_reg <= 8'd0;
                out_ok_reg    <= (xor_reg == in_byte_reg);
            end
            else
            begin
                out_kind_reg  <= KIND_PAYLOAD;
                out_byte_reg  <= in_byte_reg;
                out_index_reg <= count_reg;
                out_ok_reg    <= 1'b0;
            end
        end
    end

    assign res_valid     = out_valid_reg;
    assign result_kind   = out_kind_reg;
    assign payload_byte  = out_byte_reg;
    assign payload_index = out_index_reg;
    assign command_code  = out_cmd_reg;
    assign frame_length  = out_len_reg;
    assign checksum_ok   = out_ok_reg;

endmodule

@@ rtl/msp_rx_checker.sv @@
module msp_rx_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic       result_kind,
    input logic [7:0] payload_byte,
    input logic [7:0] payload_index,
    input logic [7:0] command_code,
    input logic [7:0] frame_length,
    input logic       checksum_ok
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(result_kind) && $stable(payload_byte)
            && $stable(payload_index) && $stable(command_code)
            && $stable(frame_length) && $stable(checksum_ok))
        else $error("result changed while stalled");

    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind |-> payload_byte == 8'd0 && payload_index == 8'd0)
        else $error("end of frame carries payload data");

    a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !result_kind |-> !checksum_ok && payload_index != frame_length)
        else $error("payload result with bad index or check flag");

endmodule

bind msp_frame_receiver_core msp_rx_checker u_msp_rx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .result_kind   (result_kind),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .command_code  (command_code),
    .frame_length  (frame_length),
    .checksum_ok   (checksum_ok)
);
